/* sv/dsa_pkg.sv */
// dsa_pkg: shared types, codes and constants of the double-ended stack allocator
// no dependencies; used by the interfaces, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 24;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam int STACK_DEPTH_DEF  = 16;
	localparam int HEADER_BYTES_DEF = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NOSPACE  = 3'd1,
		ST_DISABLED = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REGION_BASE = 2'd0,
		CFG_REGION_SIZE = 2'd1,
		CFG_ENABLED     = 2'd2
	} cfg_index_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

endpackage

`default_nettype wire

/* sv/dsa_if.sv */
// dsa_if: valid/ready channel interfaces for commands, results and register writes
// depends on dsa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dsa_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [dsa_pkg::CMD_W-1:0]  command;
	logic [dsa_pkg::SIZE_W-1:0] request_bytes;

	modport source (output valid, command, request_bytes, input ready);
	modport sink (input valid, command, request_bytes, output ready);
endinterface

interface dsa_res_if;
	logic                         valid;
	logic                         ready;
	logic [dsa_pkg::STATUS_W-1:0] status;
	logic [dsa_pkg::ADDR_W-1:0]   block_address;
	logic [dsa_pkg::ADDR_W-1:0]   front_marker;
	logic [dsa_pkg::ADDR_W-1:0]   back_marker;
	logic [dsa_pkg::SIZE_W-1:0]   free_bytes;
	logic [dsa_pkg::SIZE_W-1:0]   used_bytes;

	modport source (output valid, status, block_address, front_marker, back_marker,
		free_bytes, used_bytes, input ready);
	modport sink (input valid, status, block_address, front_marker, back_marker,
		free_bytes, used_bytes, output ready);
endinterface

interface dsa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dsa_pkg::CFG_INDEX_W-1:0] index;
	logic [dsa_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/double_ended_stack_allocator_top.sv */
// double_ended_stack_allocator_top: two stacks in one region, markers kept in two rams
// depends on dsa_pkg, dsa_if (dsa_cmd_if, dsa_res_if, dsa_cfg_if) and dsa_ram
//
//   channel  dir  payload                                              handshake
//   cmd      in   command, request_bytes                               valid/ready
//   res      out  status, block_address, front_marker, back_marker,    valid/ready
//                 free_bytes, used_bytes
//   cfg      in   index, data (0 region_base, 1 region_size, 2 enabled) valid/ready
//
// a command is accepted, then executed once the marker ram read is back
// one command is in flight; the next is accepted while the previous result waits in res
// execute stalls while the result register is still full and res.ready is low
// reset clears offsets, counts, registers and handshake state; the marker rams need no clearing
// cfg is always ready; any register write empties both stacks
`timescale 1ns / 1ps
`default_nettype none

module double_ended_stack_allocator_top #(
	parameter int STACK_DEPTH  = dsa_pkg::STACK_DEPTH_DEF,
	parameter int HEADER_BYTES = dsa_pkg::HEADER_BYTES_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	dsa_cmd_if.sink     cmd,
	dsa_res_if.source   res,
	dsa_cfg_if.sink     cfg
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = dsa_pkg::SIZE_W;
	localparam int BW = dsa_pkg::ADDR_W;

	dsa_pkg::state_t state_q, state_nxt;

	logic [BW-1:0] region_base_q;
	logic [SW-1:0] region_size_q;
	logic          enabled_q;

	logic [SW-1:0] front_off_q, back_off_q;
	logic [CW-1:0] front_cnt_q, back_cnt_q;

	dsa_pkg::cmd_t cmd_s1;
	logic [SW-1:0] bytes_s1;

	logic                    res_valid_q;
	dsa_pkg::status_t        status_q;
	logic [BW-1:0]           block_addr_q, front_mark_q, back_mark_q;
	logic [SW-1:0]           free_q, used_q;

	logic cmd_acc, cfg_acc, cfg_hit, go;

	logic [SW:0]      cost;
	logic [SW-1:0]    avail;
	dsa_pkg::status_t status_nxt;
	logic [BW-1:0]    addr_nxt;
	logic [SW-1:0]    front_nxt, back_nxt;
	logic [CW-1:0]    front_cnt_nxt, back_cnt_nxt;
	logic             front_we, back_we;
	logic [SW-1:0]    front_rd, back_rd;
	logic [CW-1:0]    front_cnt_dec, back_cnt_dec;

	assign cmd.ready = (state_q == dsa_pkg::S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_acc && (cfg.index == dsa_pkg::CFG_REGION_BASE ||
		cfg.index == dsa_pkg::CFG_REGION_SIZE || cfg.index == dsa_pkg::CFG_ENABLED);
	assign go        = (state_q == dsa_pkg::S_EXEC) && (!res_valid_q || res.ready);

	assign front_cnt_dec = front_cnt_q - CW'(1);
	assign back_cnt_dec  = back_cnt_q - CW'(1);

	// marker stacks
	dsa_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_front_ram (
		.clk     (clk),
		.we      (go && front_we),
		.waddr   (front_cnt_q[AW-1:0]),
		.wdata   (front_off_q),
		.re      (cmd_acc),
		.raddr   (front_cnt_dec[AW-1:0]),
		.rdata_q (front_rd)
	);

	dsa_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_back_ram (
		.clk     (clk),
		.we      (go && back_we),
		.waddr   (back_cnt_q[AW-1:0]),
		.wdata   (back_off_q),
		.re      (cmd_acc),
		.raddr   (back_cnt_dec[AW-1:0]),
		.rdata_q (back_rd)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dsa_pkg::S_IDLE: begin
				if (cmd_acc) begin
					state_nxt = dsa_pkg::S_EXEC;
				end
			end
			dsa_pkg::S_EXEC: begin
				if (go) begin
					state_nxt = dsa_pkg::S_IDLE;
				end
			end
			default: state_nxt = dsa_pkg::S_IDLE;
		endcase
	end

	// command execution
	always_comb begin
		cost          = {1'b0, bytes_s1} + (SW+1)'(HEADER_BYTES);
		avail         = back_off_q - front_off_q;
		status_nxt    = dsa_pkg::ST_OK;
		addr_nxt      = '0;
		front_nxt     = front_off_q;
		back_nxt      = back_off_q;
		front_cnt_nxt = front_cnt_q;
		back_cnt_nxt  = back_cnt_q;
		front_we      = 1'b0;
		back_we       = 1'b0;
		if (!enabled_q) begin
			status_nxt = dsa_pkg::ST_DISABLED;
		end else begin
			case (cmd_s1)
				dsa_pkg::CMD_PUSH_FRONT: begin
					if (cost > {1'b0, avail}) begin
						status_nxt = dsa_pkg::ST_NOSPACE;
					end else if (front_cnt_q == CW'(STACK_DEPTH)) begin
						status_nxt = dsa_pkg::ST_FULL;
					end else begin
						front_we      = 1'b1;
						front_cnt_nxt = front_cnt_q + CW'(1);
						addr_nxt      = region_base_q + {{(BW-SW){1'b0}}, front_off_q};
						front_nxt     = front_off_q + cost[SW-1:0];
					end
				end
				dsa_pkg::CMD_PUSH_BACK: begin
					if (cost > {1'b0, avail}) begin
						status_nxt = dsa_pkg::ST_NOSPACE;
					end else if (back_cnt_q == CW'(STACK_DEPTH)) begin
						status_nxt = dsa_pkg::ST_FULL;
					end else begin
						back_we      = 1'b1;
						back_cnt_nxt = back_cnt_q + CW'(1);
						back_nxt     = back_off_q - cost[SW-1:0];
						addr_nxt     = region_base_q + {{(BW-SW){1'b0}}, back_nxt}
							+ BW'(HEADER_BYTES);
					end
				end
				dsa_pkg::CMD_POP_FRONT: begin
					if (front_cnt_q == '0) begin
						status_nxt = dsa_pkg::ST_EMPTY;
					end else begin
						front_cnt_nxt = front_cnt_dec;
						front_nxt     = front_rd;
					end
				end
				dsa_pkg::CMD_POP_BACK: begin
					if (back_cnt_q == '0) begin
						status_nxt = dsa_pkg::ST_EMPTY;
					end else begin
						back_cnt_nxt = back_cnt_dec;
						back_nxt     = back_rd;
					end
				end
				dsa_pkg::CMD_CLEAR: begin
					front_nxt     = '0;
					back_nxt      = region_size_q;
					front_cnt_nxt = '0;
					back_cnt_nxt  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsa_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1   <= dsa_pkg::cmd_t'(cmd.command);
			bytes_s1 <= cmd.request_bytes;
		end
	end

	// registers, offsets and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			region_size_q <= '0;
			enabled_q     <= 1'b0;
			front_off_q   <= '0;
			back_off_q    <= '0;
			front_cnt_q   <= '0;
			back_cnt_q    <= '0;
		end else if (cfg_hit) begin
			front_off_q <= '0;
			front_cnt_q <= '0;
			back_cnt_q  <= '0;
			back_off_q  <= region_size_q;
			case (dsa_pkg::cfg_index_t'(cfg.index))
				dsa_pkg::CFG_REGION_BASE: region_base_q <= cfg.data;
				dsa_pkg::CFG_REGION_SIZE: begin
					region_size_q <= cfg.data[SW-1:0];
					back_off_q    <= cfg.data[SW-1:0];
				end
				dsa_pkg::CFG_ENABLED: enabled_q <= cfg.data[0];
				default: begin
				end
			endcase
		end else if (go) begin
			front_off_q <= front_nxt;
			back_off_q  <= back_nxt;
			front_cnt_q <= front_cnt_nxt;
			back_cnt_q  <= back_cnt_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q     <= status_nxt;
			block_addr_q <= addr_nxt;
			front_mark_q <= region_base_q + {{(BW-SW){1'b0}}, front_nxt};
			back_mark_q  <= region_base_q + {{(BW-SW){1'b0}}, back_nxt};
			free_q       <= back_nxt - front_nxt;
			used_q       <= front_nxt + (region_size_q - back_nxt);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = status_q;
	assign res.block_address = block_addr_q;
	assign res.front_marker  = front_mark_q;
	assign res.back_marker   = back_mark_q;
	assign res.free_bytes    = free_q;
	assign res.used_bytes    = used_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_cnt_q <= CW'(STACK_DEPTH) && back_cnt_q <= CW'(STACK_DEPTH))
		else $error("marker count beyond stack depth");

	a_offsets_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		front_off_q <= back_off_q)
		else $error("front top passed back top");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> state_q == dsa_pkg::S_EXEC)
		else $error("accepted item not executed");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> res_valid_q && state_q == dsa_pkg::S_IDLE)
		else $error("executed item left no result");

endmodule

`default_nettype wire

/* sv/dsa_ram.sv */
// dsa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dsa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking testbench of double_ended_stack_allocator_top
// depends on dsa_pkg, the dsa_if channel interfaces and the allocator top level
// an allocation model checks every result in order under random idling and back-pressure
`timescale 1ns / 1ps

typedef struct packed {
	dsa_pkg::status_t status;
	logic [31:0]      block_address;
	logic [31:0]      front_marker;
	logic [31:0]      back_marker;
	logic [23:0]      free_bytes;
	logic [23:0]      used_bytes;
} alloc_result_t;

class stack_alloc_scoreboard;
	localparam int DEPTH = dsa_pkg::STACK_DEPTH_DEF;
	localparam int HDR   = dsa_pkg::HEADER_BYTES_DEF;

	logic [31:0]   base;
	logic [23:0]   size;
	logic          en;
	logic [23:0]   front_off;
	logic [23:0]   back_off;
	logic [23:0]   front_stack [DEPTH];
	logic [23:0]   back_stack [DEPTH];
	int unsigned   front_n;
	int unsigned   back_n;
	alloc_result_t expected_results[$];
	int            errors;

	function new();
		base = '0;
		size = '0;
		en = 1'b0;
		errors = 0;
		clear_stacks();
	endfunction

	function void clear_stacks();
		front_off = '0;
		back_off = size;
		front_n = 0;
		back_n = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] d);
		case (idx)
			dsa_pkg::CFG_REGION_BASE: base = d;
			dsa_pkg::CFG_REGION_SIZE: size = d[23:0];
			dsa_pkg::CFG_ENABLED: en = d[0];
			default: return;
		endcase
		clear_stacks();
	endfunction

	function void note_command(logic [2:0] c, logic [23:0] b);
		alloc_result_t r;
		logic [24:0]   cost;
		logic [23:0]   avail;
		int unsigned   n;
		cost = {1'b0, b} + 25'(HDR);
		avail = back_off - front_off;
		r.status = dsa_pkg::ST_OK;
		r.block_address = '0;
		if (!en) begin
			r.status = dsa_pkg::ST_DISABLED;
		end else begin
			case (c)
				dsa_pkg::CMD_PUSH_FRONT, dsa_pkg::CMD_PUSH_BACK: begin
					n = (c == dsa_pkg::CMD_PUSH_FRONT) ? front_n : back_n;
					if (cost > {1'b0, avail}) begin
						r.status = dsa_pkg::ST_NOSPACE;
					end else if (n >= DEPTH) begin
						r.status = dsa_pkg::ST_FULL;
					end else if (c == dsa_pkg::CMD_PUSH_FRONT) begin
						front_stack[front_n] = front_off;
						front_n++;
						r.block_address = base + {8'd0, front_off};
						front_off = front_off + cost[23:0];
					end else begin
						back_stack[back_n] = back_off;
						back_n++;
						back_off = back_off - cost[23:0];
						r.block_address = base + {8'd0, back_off} + 32'(HDR);
					end
				end
				dsa_pkg::CMD_POP_FRONT: begin
					if (front_n == 0) begin
						r.status = dsa_pkg::ST_EMPTY;
					end else begin
						front_n--;
						front_off = front_stack[front_n];
					end
				end
				dsa_pkg::CMD_POP_BACK: begin
					if (back_n == 0) begin
						r.status = dsa_pkg::ST_EMPTY;
					end else begin
						back_n--;
						back_off = back_stack[back_n];
					end
				end
				dsa_pkg::CMD_CLEAR: begin
					clear_stacks();
				end
				default: ;
			endcase
		end
		r.front_marker = base + {8'd0, front_off};
		r.back_marker = base + {8'd0, back_off};
		r.free_bytes = back_off - front_off;
		r.used_bytes = front_off + (size - back_off);
		expected_results.push_back(r);
	endfunction

	function void compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, field, exp_v, got_v);
			errors++;
		end
	endfunction

	function void check_result(alloc_result_t got);
		alloc_result_t e;
		if (expected_results.size() == 0) begin
			$display("%0t unexpected result: expected none actual %h", $time, got);
			errors++;
			return;
		end
		e = expected_results.pop_front();
		compare_field("status", 32'(e.status), 32'(got.status));
		compare_field("block_address", e.block_address, got.block_address);
		compare_field("front_marker", e.front_marker, got.front_marker);
		compare_field("back_marker", e.back_marker, got.back_marker);
		compare_field("free_bytes", 32'(e.free_bytes), 32'(got.free_bytes));
		compare_field("used_bytes", 32'(e.used_bytes), 32'(got.used_bytes));
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	dsa_cmd_if cmd_if ();
	dsa_res_if res_if ();
	dsa_cfg_if cfg_if ();

	stack_alloc_scoreboard sb = new();

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_ask = 0;
	logic [23:0] cur_size = '0;

	double_ended_stack_allocator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// accepted items feed the scoreboard
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.write_reg(cfg_if.index, cfg_if.data);
			if (cmd_if.valid && cmd_if.ready)
				sb.note_command(cmd_if.command, cmd_if.request_bytes);
			if (res_if.valid && res_if.ready) begin
				got.status = dsa_pkg::status_t'(res_if.status);
				got.block_address = res_if.block_address;
				got.front_marker = res_if.front_marker;
				got.back_marker = res_if.back_marker;
				got.free_bytes = res_if.free_bytes;
				got.used_bytes = res_if.used_bytes;
				sb.check_result(got);
			end
		end
	end

	// result side ready, with random stalls and long hold-offs
	initial begin
		int hold_left;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[double_ended_stack_allocator_top] ERROR");
		$finish;
	end

	task automatic send_cmd(input logic [2:0] c, input logic [23:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= c;
		cmd_if.request_bytes <= b;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
	endtask

	task automatic write_cfg(input dsa_pkg::cfg_index_t idx, input logic [31:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= d;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	task automatic program_region(input logic [31:0] b, input logic [23:0] s, input logic e);
		write_cfg(dsa_pkg::CFG_REGION_BASE, b);
		write_cfg(dsa_pkg::CFG_REGION_SIZE, {8'd0, s});
		write_cfg(dsa_pkg::CFG_ENABLED, {31'd0, e});
		cfg_if.valid <= 1'b0;
		cur_size = s;
	endtask

	// lower valid and let every outstanding result drain
	task automatic drain();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [23:0] pick_bytes(input logic [23:0] s);
		int unsigned k;
		logic [31:0] r;
		k = $urandom_range(99);
		r = $urandom();
		if (k < 50)
			return 24'($urandom_range(15));
		else if (k < 80)
			return 24'($urandom_range(s >> 2));
		return r[23:0];
	endfunction

	task automatic run_random(input int n);
		int          sent;
		int          len;
		int          kind;
		logic        side;
		logic [31:0] r;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(99);
			len = $urandom_range(18, 1);
			side = 1'($urandom_range(1));
			if (kind < 40) begin
				for (int i = 0; i < len; i++)
					send_cmd(side ? dsa_pkg::CMD_PUSH_BACK : dsa_pkg::CMD_PUSH_FRONT,
						pick_bytes(cur_size));
			end else if (kind < 70) begin
				for (int i = 0; i < len; i++) begin
					r = $urandom();
					send_cmd(side ? dsa_pkg::CMD_POP_BACK : dsa_pkg::CMD_POP_FRONT, r[23:0]);
				end
			end else if (kind < 95) begin
				len = 1;
				send_cmd(3'($urandom_range(7)), pick_bytes(cur_size));
			end else begin
				len = 1;
				r = $urandom();
				send_cmd(dsa_pkg::CMD_CLEAR, r[23:0]);
			end
			sent += len;
		end
	endtask

	task automatic run_directed();
		// disabled after reset, clear included
		send_cmd(dsa_pkg::CMD_PUSH_FRONT, 24'd8);
		send_cmd(dsa_pkg::CMD_CLEAR, 24'd0);
		drain();
		program_region(32'hFFFF_FFF0, 24'd200, 1'b1);
		// markers wrap past the top of the address space
		send_cmd(dsa_pkg::CMD_POP_FRONT, 24'hFFFFFF);
		send_cmd(dsa_pkg::CMD_POP_BACK, 24'd0);
		send_cmd(dsa_pkg::CMD_PUSH_FRONT, 24'd0);
		send_cmd(dsa_pkg::CMD_PUSH_BACK, 24'd0);
		send_cmd(dsa_pkg::CMD_PUSH_FRONT, 24'hFFFFFF);
		send_cmd(dsa_pkg::CMD_PUSH_BACK, 24'd100);
		// exact fit leaves no free bytes
		send_cmd(dsa_pkg::CMD_PUSH_FRONT, 24'd84);
		send_cmd(dsa_pkg::CMD_PUSH_BACK, 24'd0);
		for (int u = dsa_pkg::CMD_CLEAR + 1; u < 8; u++)
			send_cmd(3'(u), 24'hA5A5A5);
		send_cmd(dsa_pkg::CMD_POP_FRONT, 24'd0);
		send_cmd(dsa_pkg::CMD_POP_BACK, 24'd0);
		send_cmd(dsa_pkg::CMD_POP_FRONT, 24'd0);
		send_cmd(dsa_pkg::CMD_POP_BACK, 24'd0);
		send_cmd(dsa_pkg::CMD_POP_FRONT, 24'd0);
		send_cmd(dsa_pkg::CMD_PUSH_BACK, 24'd16);
		send_cmd(dsa_pkg::CMD_CLEAR, 24'h5A5A5A);
		send_cmd(dsa_pkg::CMD_POP_BACK, 24'd0);
	endtask

	initial begin
		logic [31:0] r;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.command = dsa_pkg::CMD_PUSH_FRONT;
		cmd_if.request_bytes = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = dsa_pkg::CFG_REGION_BASE;
		cfg_if.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < 6; p++) begin
			drain();
			repeat (4) @(posedge clk);
			r = $urandom();
			case (p)
				0: program_region(32'h0000_0000, 24'hFFFFFF, 1'b1);
				1: program_region(32'hFFFF_FFFF, 24'd400, 1'b1);
				2: program_region(r, 24'd0, 1'b1);
				3: program_region(r, 24'($urandom_range(2000, 64)), 1'b0);
				4: program_region(r, 24'd1000, 1'b1);
				default: program_region(32'hFFFF_0000, 24'hFFFFFF, 1'b1);
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
			endcase
			if (p == 0) begin
				run_random(50);
				// long hold-off while commands keep coming
				hold_ask = 300;
				run_random(150);
			end else if (p == 4) begin
				run_random(100);
				drain();
				run_random(100);
			end else if (p == 2 || p == 3) begin
				run_random(40);
			end else begin
				run_random(200);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[double_ended_stack_allocator_top] OK");
		else
			$display("[double_ended_stack_allocator_top] ERROR");
		$finish;
	end
endmodule
